### src/mafs_pkg.sv
package mafs_pkg;

	// Result status codes, in check order
	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_NO_SYNC     = 3'd1,
		ST_RSV_VERSION = 3'd2,
		ST_RSV_LAYER   = 3'd3,
		ST_BAD_BITRATE = 3'd4,
		ST_BAD_RATE    = 3'd5,
		ST_FREE_FORMAT = 3'd6
	} status_t;

	// Header field codes
	localparam logic [31:0] SYNC_MASK   = 32'hffe0_0000;
	localparam logic [1:0]  VER_MPEG1   = 2'b11;
	localparam logic [1:0]  VER_RSV     = 2'b01;
	localparam logic [1:0]  VER_MPEG25  = 2'b00;
	localparam logic [1:0]  LAY_RSV     = 2'd0;
	localparam logic [1:0]  LAY_CODE_L3 = 2'd1;
	localparam logic [1:0]  LAY_CODE_L1 = 2'd3;
	localparam logic [3:0]  BR_FREE     = 4'h0;
	localparam logic [3:0]  BR_BAD      = 4'hf;
	localparam logic [1:0]  SR_BAD      = 2'd3;

	// Scale factors of the frame formulas (bytes per kbit/s times rate)
	localparam logic [19:0] SCALE_L1  = 20'd12000;
	localparam logic [19:0] SCALE_L23 = 20'd144000;

	// Reciprocals of the base rates, exact for numerators below 2^27
	localparam int QSHIFT = 43;
	localparam logic [28:0] RECIP_44K1 =
		29'(((64'd1 << QSHIFT) + 64'd44099) / 64'd44100);
	localparam logic [28:0] RECIP_48K =
		29'(((64'd1 << QSHIFT) + 64'd47999) / 64'd48000);
	localparam logic [28:0] RECIP_32K =
		29'(((64'd1 << QSHIFT) + 64'd31999) / 64'd32000);

	// Bitrate in kbit/s, indexed by LSF flag, layer code and bitrate index
	localparam logic [8:0] KBPS [0:1][0:3][0:15] = '{
		'{
			'{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
			'{0, 32, 40, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 0},
			'{0, 32, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 384, 0},
			'{0, 32, 64, 96, 128, 160, 192, 224, 256, 288, 320, 352, 384, 416, 448, 0}
		},
		'{
			'{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
			'{0, 8, 16, 24, 32, 40, 48, 56, 64, 80, 96, 112, 128, 144, 160, 0},
			'{0, 8, 16, 24, 32, 40, 48, 56, 64, 80, 96, 112, 128, 144, 160, 0},
			'{0, 32, 48, 56, 64, 80, 96, 112, 128, 144, 160, 176, 192, 224, 256, 0}
		}
	};

	function automatic logic [15:0] base_rate(input logic [1:0] sr);
		case (sr)
			2'd0:    base_rate = 16'd44100;
			2'd1:    base_rate = 16'd48000;
			2'd2:    base_rate = 16'd32000;
			default: base_rate = 16'd0;
		endcase
	endfunction

	function automatic logic [28:0] base_recip(input logic [1:0] sr);
		case (sr)
			2'd0:    base_recip = RECIP_44K1;
			2'd1:    base_recip = RECIP_48K;
			default: base_recip = RECIP_32K;
		endcase
	endfunction

	// Fields that ride along to the output stage
	typedef struct packed {
		status_t     status;
		logic [1:0]  layer;
		logic [15:0] rate;
		logic        pad;
		logic        layer1;
	} side_t;

	// Decoded header
	typedef struct packed {
		side_t       side;
		logic [8:0]  kbps;
		logic [19:0] scale;
		logic [1:0]  sr;
	} dec_t;

endpackage

### src/mafs_decode.sv
module mafs_decode (
	input  logic               clk,
	input  logic               en,
	input  logic [31:0]        header_word,
	output mafs_pkg::dec_t     dec_s1
);

	logic [1:0]        ver;
	logic [1:0]        lay;
	logic [3:0]        br;
	logic [1:0]        sr;
	logic              lsf;
	logic              m25;
	logic [1:0]        shift;
	logic              ok;
	mafs_pkg::status_t st;
	mafs_pkg::dec_t    dec;

	assign ver = header_word[20:19];
	assign lay = header_word[18:17];
	assign br  = header_word[15:12];
	assign sr  = header_word[11:10];

	// Run the checks in order, first failure wins
	always_comb begin
		if ((header_word & mafs_pkg::SYNC_MASK) != mafs_pkg::SYNC_MASK)
			st = mafs_pkg::ST_NO_SYNC;
		else if (ver == mafs_pkg::VER_RSV)
			st = mafs_pkg::ST_RSV_VERSION;
		else if (lay == mafs_pkg::LAY_RSV)
			st = mafs_pkg::ST_RSV_LAYER;
		else if (br == mafs_pkg::BR_BAD)
			st = mafs_pkg::ST_BAD_BITRATE;
		else if (sr == mafs_pkg::SR_BAD)
			st = mafs_pkg::ST_BAD_RATE;
		else if (br == mafs_pkg::BR_FREE)
			st = mafs_pkg::ST_FREE_FORMAT;
		else
			st = mafs_pkg::ST_OK;
	end

	assign ok    = (st == mafs_pkg::ST_OK);
	assign lsf   = (ver != mafs_pkg::VER_MPEG1);
	assign m25   = (ver == mafs_pkg::VER_MPEG25);
	assign shift = {1'b0, lsf} + {1'b0, m25};

	// Derive layer, rate, bitrate and scale; zero layer, rate, flags and bitrate on error
	always_comb begin
		dec.side.status = st;
		dec.side.layer  = ok ? 2'(3'd4 - {1'b0, lay}) : 2'd0;
		dec.side.rate   = ok ? (mafs_pkg::base_rate(sr) >> shift) : 16'd0;
		dec.side.pad    = ok & header_word[9];
		dec.side.layer1 = ok & (lay == mafs_pkg::LAY_CODE_L1);
		dec.kbps        = ok ? mafs_pkg::KBPS[lsf][lay][br] : 9'd0;
		dec.sr          = sr;
		// rate is base >> shift, so dividing by it is scaling up by 2^shift
		if (lay == mafs_pkg::LAY_CODE_L1)
			dec.scale = mafs_pkg::SCALE_L1 << shift;
		else if (lay == mafs_pkg::LAY_CODE_L3)
			dec.scale = mafs_pkg::SCALE_L23 << (shift - {1'b0, lsf});
		else
			dec.scale = mafs_pkg::SCALE_L23 << shift;
	end

	// Stage 1 register
	always_ff @(posedge clk) begin
		if (en)
			dec_s1 <= dec;
	end

endmodule

### src/mafs_divide.sv
module mafs_divide (
	input  logic              clk,
	input  logic              en2,
	input  logic              en3,
	input  mafs_pkg::dec_t    dec_s1,
	output mafs_pkg::side_t   side_s3,
	output logic [11:0]       quot_s3
);

	localparam int NUM_W  = 27;
	localparam int PROD_W = NUM_W + 29;

	logic [28:0]       num_full;
	logic [NUM_W-1:0]  num_s2;
	logic [28:0]       recip_s2;
	mafs_pkg::side_t   side_s2;
	logic [PROD_W-1:0] prod;

	// Numerator: bitrate times scale, below 2^27 for every valid header
	assign num_full = {20'd0, dec_s1.kbps} * {9'd0, dec_s1.scale};

	always_ff @(posedge clk) begin
		if (en2) begin
			num_s2   <= num_full[NUM_W-1:0];
			recip_s2 <= mafs_pkg::base_recip(dec_s1.sr);
			side_s2  <= dec_s1.side;
		end
	end

	// Divide by the base rate through its reciprocal
	assign prod = {29'd0, num_s2} * {{NUM_W{1'b0}}, recip_s2};

	always_ff @(posedge clk) begin
		if (en3) begin
			quot_s3 <= prod[mafs_pkg::QSHIFT +: 12];
			side_s3 <= side_s2;
		end
	end

endmodule

### src/mpeg_audio_frame_size.sv
// MPEG audio header checker and frame length unit.
// Pipeline: input transfer to result valid runs through four register
// stages (decode, numerator multiply, reciprocal multiply, output stage).
// Throughput: one header per cycle; a stage holds only when it and every stage
// after it are full and the output is held.
// Reset: arst_n clears all stage valid bits asynchronously; data is not reset.
module mpeg_audio_frame_size (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] header_word,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [11:0] frame_bytes,
	output logic [2:0]  status,
	output logic [1:0]  layer_number,
	output logic [15:0] sample_rate_hz
);

	logic            v_s1, v_s2, v_s3, v_s4;
	logic            rdy1, rdy2, rdy3, rdy4;
	mafs_pkg::dec_t  dec_s1;
	mafs_pkg::side_t side_s3;
	logic [11:0]     quot_s3;
	logic [11:0]     slots;
	logic [11:0]     bytes_s4;
	logic [2:0]      status_s4;
	logic [1:0]      layer_s4;
	logic [15:0]     rate_s4;

	// Stage advances when empty or when the next stage moves
	assign rdy4     = !v_s4 || out_ready;
	assign rdy3     = !v_s3 || rdy4;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign in_ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
		end
	end

	mafs_decode u_decode (
		.clk         (clk),
		.en          (in_valid && rdy1),
		.header_word (header_word),
		.dec_s1      (dec_s1)
	);

	mafs_divide u_divide (
		.clk     (clk),
		.en2     (v_s1 && rdy2),
		.en3     (v_s2 && rdy3),
		.dec_s1  (dec_s1),
		.side_s3 (side_s3),
		.quot_s3 (quot_s3)
	);

	// Add padding slot; layer I slots are four bytes
	assign slots = quot_s3 + {11'd0, side_s3.pad};

	always_ff @(posedge clk) begin
		if (v_s3 && rdy4) begin
			bytes_s4  <= side_s3.layer1 ? {slots[9:0], 2'b00} : slots;
			status_s4 <= side_s3.status;
			layer_s4  <= side_s3.layer;
			rate_s4   <= side_s3.rate;
		end
	end

	assign out_valid      = v_s4;
	assign frame_bytes    = bytes_s4;
	assign status         = status_s4;
	assign layer_number   = layer_s4;
	assign sample_rate_hz = rate_s4;

	// Errors carry zero result fields
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != mafs_pkg::ST_OK) |->
			(frame_bytes == 12'd0 && layer_number == 2'd0 && sample_rate_hz == 16'd0))
		else $error("error result with nonzero fields");

	// Valid headers give a layer, a rate and a length
	a_ok_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == mafs_pkg::ST_OK) |->
			(layer_number != 2'd0 && sample_rate_hz != 16'd0 && frame_bytes != 12'd0))
		else $error("valid header with empty result");

	// Layer I lengths are whole slots of four bytes
	a_l1_slots: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == mafs_pkg::ST_OK && layer_number == 2'd1) |->
			(frame_bytes[1:0] == 2'b00))
		else $error("layer I length not a multiple of four");

	// Input stalls only when every stage holds an item
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (v_s1 && v_s2 && v_s3 && v_s4 && !out_ready))
		else $error("input stalled with a bubble in the pipeline");

endmodule
